// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dptr_pkg.sv =====
package dptr_pkg;

  localparam int LEVEL_BITS = 12;
  localparam int NUM_PADS   = 4;
  localparam int TIME_W     = 32;
  localparam int ROLL_W     = 16;
  localparam int DEB_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4 * LEVEL_BITS;

  // Pad positions in the hit vectors
  localparam int PAD_DON_L = 0;
  localparam int PAD_DON_R = 1;
  localparam int PAD_KA_L  = 2;
  localparam int PAD_KA_R  = 3;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST     = 16'd25;
  localparam logic [TIME_W-1:0] ROLL_TIMEOUT_RST = 32'd500;
  localparam logic [ROLL_W-1:0] ROLL_MAX         = '1;

  typedef logic [LEVEL_BITS-1:0] lvl_t;

  // Four lanes packed from the low bits upward: left don first
  typedef struct packed {
    lvl_t ka_r;
    lvl_t ka_l;
    lvl_t don_r;
    lvl_t don_l;
  } lanes_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIG_THR     = 3'd0,
    REG_DBL_THR      = 3'd1,
    REG_DBL_MODE     = 3'd2,
    REG_DEBOUNCE     = 3'd3,
    REG_ROLL_TIMEOUT = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_SINGLE = 2'd0,
    MODE_THRESH = 2'd1,
    MODE_ALWAYS = 2'd2
  } dbl_mode_t;

  typedef struct packed {
    lvl_t              don_left_raw;
    lvl_t              don_right_raw;
    lvl_t              ka_left_raw;
    lvl_t              ka_right_raw;
    logic [TIME_W-1:0] now_ms;
  } in_t;

  typedef struct packed {
    logic              don_left_hit;
    logic              don_right_hit;
    logic              ka_left_hit;
    logic              ka_right_hit;
    logic [ROLL_W-1:0] roll_now;
    logic [ROLL_W-1:0] roll_last;
  } out_t;

  // Resolver settings, grouped
  typedef struct packed {
    lanes_t     trig_thr;
    lanes_t     dbl_thr;
    logic [1:0] dbl_mode;
  } res_cfg_t;

endpackage

// ===== rtl/dptr_resolve.sv =====
// Pair choice and per-pad requested state for one set of levels
module dptr_resolve (
  input  dptr_pkg::lanes_t                levels,
  input  dptr_pkg::res_cfg_t              cfg,
  output logic [dptr_pkg::NUM_PADS-1:0]   want
);

  // Requested states {left, right} for one pair
  function automatic logic [1:0] pair_want(
    input dptr_pkg::lvl_t l,
    input dptr_pkg::lvl_t r,
    input dptr_pkg::lvl_t tl,
    input dptr_pkg::lvl_t tr,
    input dptr_pkg::lvl_t dl,
    input dptr_pkg::lvl_t dr,
    input logic [1:0]     mode
  );
    logic over_trig;
    logic over_dbl;
    logic [1:0] single;
    logic [1:0] res;
    over_trig = (l > tl) || (r > tr);
    over_dbl  = (l > dl) || (r > dr);
    // single fire: stronger pad on, twin on if above half; tie goes right
    if (!over_trig) begin
      single = 2'b00;
    end else if (l > r) begin
      single = {1'b1, r > (l >> 1)};
    end else begin
      single = {l > (r >> 1), 1'b1};
    end
    case (mode)
      dptr_pkg::MODE_THRESH: res = over_dbl ? 2'b11 : single;
      dptr_pkg::MODE_ALWAYS: res = {over_trig, over_trig};
      default:               res = single;
    endcase
    return res;
  endfunction

  dptr_pkg::lvl_t max_don;
  dptr_pkg::lvl_t max_ka;
  logic           don_sel;
  logic [1:0]     don_want;
  logic [1:0]     ka_want;

  assign max_don = (levels.don_l > levels.don_r) ? levels.don_l : levels.don_r;
  assign max_ka  = (levels.ka_l > levels.ka_r) ? levels.ka_l : levels.ka_r;
  assign don_sel = max_don > max_ka;

  assign don_want = pair_want(levels.don_l, levels.don_r,
                              cfg.trig_thr.don_l, cfg.trig_thr.don_r,
                              cfg.dbl_thr.don_l, cfg.dbl_thr.don_r, cfg.dbl_mode);
  assign ka_want  = pair_want(levels.ka_l, levels.ka_r,
                              cfg.trig_thr.ka_l, cfg.trig_thr.ka_r,
                              cfg.dbl_thr.ka_l, cfg.dbl_thr.ka_r, cfg.dbl_mode);

  // Losing pair is driven off
  always_comb begin
    want = '0;
    if (don_sel) begin
      want[dptr_pkg::PAD_DON_L] = don_want[1];
      want[dptr_pkg::PAD_DON_R] = don_want[0];
    end else begin
      want[dptr_pkg::PAD_KA_L] = ka_want[1];
      want[dptr_pkg::PAD_KA_R] = ka_want[0];
    end
  end

endmodule

// ===== rtl/drum_pad_trigger_resolver.sv =====
// Drum pad trigger resolver.
// Input channel (in_valid / in_stall / in_data): one request carries four pad
// levels and a millisecond timestamp. Result channel (out_valid / out_stall /
// out_data): one result per request with the four debounced hit states and
// the current and last roll lengths, in request order.
// Configuration (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// write only while no request is in flight.
// A request is registered in the input register on acceptance, resolved
// against the pad and roll state while it waits there and lands in the
// output register when that stage advances.
// Throughput is one request per cycle while no result is stalled; the
// single resolve stage updates the state once per request.
// When out_stall holds a waiting result, the resolve stage stops and keeps
// one request; in_stall rises only once that stage is also full.
// Synchronous reset clears the pad states, change times, roll state and both
// valid flags, and loads the register defaults (debounce 25 ms, roll
// timeout 500 ms, thresholds and mode zero).
module drum_pad_trigger_resolver (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  dptr_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output dptr_pkg::out_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dptr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dptr_pkg::CFG_DATA_W-1:0]     cfg_data
);

`include "assert_macros.svh"

  localparam int NP = dptr_pkg::NUM_PADS;

  // Configuration registers
  dptr_pkg::lanes_t                 trig_thr_r;
  dptr_pkg::lanes_t                 dbl_thr_r;
  logic [1:0]                       dbl_mode_r;
  logic [dptr_pkg::DEB_W-1:0]       debounce_r;
  logic [dptr_pkg::TIME_W-1:0]      roll_timeout_r;

  // Pipeline
  logic                             s1_valid_r;
  dptr_pkg::in_t                    s1_r;
  logic                             out_valid_r;
  dptr_pkg::out_t                   out_r;
  logic                             advance;
  logic                             upd;

  // Block state
  logic [NP-1:0]                    pad_active_r;
  logic [NP-1:0]                    pad_active_nxt;
  logic [dptr_pkg::TIME_W-1:0]      pad_last_r [NP];
  logic [dptr_pkg::TIME_W-1:0]      last_hit_r;
  logic [dptr_pkg::ROLL_W-1:0]      roll_count_r;
  logic [dptr_pkg::ROLL_W-1:0]      roll_count_nxt;
  logic [dptr_pkg::ROLL_W-1:0]      roll_prev_r;
  logic [dptr_pkg::ROLL_W-1:0]      roll_prev_nxt;

  dptr_pkg::lanes_t                 levels;
  dptr_pkg::res_cfg_t               res_cfg;
  logic [NP-1:0]                    want;
  logic [NP-1:0]                    change;
  logic [NP-1:0]                    rises;
  logic [dptr_pkg::TIME_W-1:0]      now;
  logic [dptr_pkg::TIME_W-1:0]      idle;
  logic                             timed_out;
  logic [dptr_pkg::ROLL_W-1:0]      roll_base;
  logic [dptr_pkg::ROLL_W:0]        roll_sum;

  assign cfg_ready = 1'b1;

  // Config writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_thr_r     <= '0;
      dbl_thr_r      <= '0;
      dbl_mode_r     <= dptr_pkg::MODE_SINGLE;
      debounce_r     <= dptr_pkg::DEBOUNCE_RST;
      roll_timeout_r <= dptr_pkg::ROLL_TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dptr_pkg::REG_TRIG_THR:     trig_thr_r     <= dptr_pkg::lanes_t'(cfg_data);
        dptr_pkg::REG_DBL_THR:      dbl_thr_r      <= dptr_pkg::lanes_t'(cfg_data);
        dptr_pkg::REG_DBL_MODE:     dbl_mode_r     <= cfg_data[1:0];
        dptr_pkg::REG_DEBOUNCE:     debounce_r     <= cfg_data[dptr_pkg::DEB_W-1:0];
        dptr_pkg::REG_ROLL_TIMEOUT: roll_timeout_r <= cfg_data[dptr_pkg::TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: stage moves when the output register is free or being taken
  assign advance   = !out_valid_r || !out_stall;
  assign upd       = s1_valid_r && advance;
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_r <= in_data;
    end
  end

  // Pair choice and requested states
  assign levels  = {s1_r.ka_right_raw, s1_r.ka_left_raw,
                    s1_r.don_right_raw, s1_r.don_left_raw};
  assign res_cfg = {trig_thr_r, dbl_thr_r, dbl_mode_r};

  dptr_resolve u_resolve (
    .levels (levels),
    .cfg    (res_cfg),
    .want   (want)
  );

  assign now = s1_r.now_ms;

  // Debounce: change only after the hold time, wrap-safe difference
  always_comb begin
    logic [dptr_pkg::TIME_W-1:0] since;
    for (int i = 0; i < NP; i++) begin
      since          = now - pad_last_r[i];
      change[i]      = (want[i] != pad_active_r[i]) &&
                       (since >= {{(dptr_pkg::TIME_W - dptr_pkg::DEB_W){1'b0}}, debounce_r});
      pad_active_nxt[i] = change[i] ? want[i] : pad_active_r[i];
    end
  end

  // Roll: timeout first, then add this request's rising edges
  assign idle      = now - last_hit_r;
  assign timed_out = idle > roll_timeout_r;
  assign roll_base = timed_out ? '0 : roll_count_r;
  assign roll_prev_nxt = (timed_out && (roll_count_r > dptr_pkg::ROLL_W'(1))) ?
                         roll_count_r : roll_prev_r;
  assign rises     = pad_active_nxt & ~pad_active_r;
  assign roll_sum  = {1'b0, roll_base} + (dptr_pkg::ROLL_W + 1)'($countones(rises));
  assign roll_count_nxt = roll_sum[dptr_pkg::ROLL_W] ? dptr_pkg::ROLL_MAX :
                          roll_sum[dptr_pkg::ROLL_W-1:0];

  // State update, once per resolved request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_active_r <= '0;
      last_hit_r   <= '0;
      roll_count_r <= '0;
      roll_prev_r  <= '0;
      for (int i = 0; i < NP; i++) begin
        pad_last_r[i] <= '0;
      end
    end else if (upd) begin
      pad_active_r <= pad_active_nxt;
      roll_count_r <= roll_count_nxt;
      roll_prev_r  <= roll_prev_nxt;
      if (|rises) begin
        last_hit_r <= now;
      end
      for (int i = 0; i < NP; i++) begin
        if (change[i]) begin
          pad_last_r[i] <= now;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      out_r.don_left_hit  <= pad_active_nxt[dptr_pkg::PAD_DON_L];
      out_r.don_right_hit <= pad_active_nxt[dptr_pkg::PAD_DON_R];
      out_r.ka_left_hit   <= pad_active_nxt[dptr_pkg::PAD_KA_L];
      out_r.ka_right_hit  <= pad_active_nxt[dptr_pkg::PAD_KA_R];
      out_r.roll_now      <= roll_count_nxt;
      out_r.roll_last     <= roll_prev_nxt;
    end
  end

  // Checks
  `ASSERT_NEXT(a_stall_freezes_state, clk, rst_n, out_valid_r && out_stall,
               roll_count_r == $past(roll_count_r) && pad_active_r == $past(pad_active_r),
               "state moved while the result was stalled")
  `ASSERT_IMPL(a_out_roll_matches, clk, rst_n, out_valid_r,
               out_r.roll_now == roll_count_r && out_r.roll_last == roll_prev_r,
               "waiting result disagrees with roll state")
  `ASSERT_IMPL(a_out_hits_match, clk, rst_n, out_valid_r,
               out_r.don_left_hit == pad_active_r[dptr_pkg::PAD_DON_L] &&
               out_r.ka_right_hit == pad_active_r[dptr_pkg::PAD_KA_R],
               "waiting result disagrees with pad state")
  `ASSERT_NEXT(a_resolve_fills_out, clk, rst_n, upd, out_valid_r,
               "resolved request did not reach the output register")

endmodule
